// ===== src/rcsw_pkg.sv =====
// Package for the RTS/CTS stop-and-wait link controller.
// Holds the transfer payload structs and the command, packet and event codes.
// No dependencies.
package rcsw_pkg;

    // Input command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PKT  = 2'd1;
    localparam logic [1:0] CMD_BAD  = 2'd2;
    localparam logic [1:0] CMD_KICK = 2'd3;

    // Packet type codes, shared by received and sent packets
    localparam logic [2:0] PKT_RTS  = 3'd0;
    localparam logic [2:0] PKT_CTS  = 3'd1;
    localparam logic [2:0] PKT_DATA = 3'd2;
    localparam logic [2:0] PKT_ACK  = 3'd3;
    localparam logic [2:0] PKT_NACK = 3'd4;
    localparam logic [2:0] PKT_HALT = 3'd5;

    // What the radio sends this step
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_CTRL = 2'd1;
    localparam logic [1:0] SEND_DATA = 2'd2;

    // Application events
    localparam logic [1:0] APP_NONE      = 2'd0;
    localparam logic [1:0] APP_DELIVERED = 2'd1;
    localparam logic [1:0] APP_TIMEOUT   = 2'd2;

    // Link state codes as seen on the result
    localparam logic [1:0] LINK_STANDBY   = 2'd0;
    localparam logic [1:0] LINK_WAIT_CTS  = 2'd1;
    localparam logic [1:0] LINK_WAIT_ACK  = 2'd2;
    localparam logic [1:0] LINK_WAIT_DATA = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_RETRIES = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Register widths and reset values
    localparam int unsigned RETRY_W = 4;
    localparam int unsigned CFG_W   = 16;
    localparam logic [RETRY_W-1:0] RETRY_SAT           = 4'd15;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET   = 4'd3;
    localparam logic [CFG_W-1:0]   ACK_TIMEOUT_RESET   = 16'd500;

    // One input item
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] pkt_type;
        logic [7:0] pkt_seq;
        logic [7:0] pkt_frag;
        logic       radio_ok;
        logic       tx_has_data;
        logic [7:0] head_seq;
        logic [7:0] head_frag;
        logic       head_is_last;
        logic       frag_accepted;
        logic       message_complete;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [1:0] send_kind;
        logic [2:0] send_type;
        logic [7:0] send_seq;
        logic [7:0] send_frag;
        logic [1:0] app_event;
        logic       queue_advance;
        logic       queue_flush;
        logic       reassembly_clear;
        logic [1:0] link_state;
    } t_out_item;

endpackage

// ===== src/rts_cts_stop_and_wait_link.sv =====
// RTS/CTS stop-and-wait link controller, top level.
// Depends on rcsw_pkg for payload structs and codes.
//
// Each transfer on the input channel is one link event (tick, packet received,
// bad frame or standby kick) and yields exactly one result transfer naming the
// packet to send, the application event, the queue and reassembly actions and
// the link state after the event. An event is captured in an input register,
// resolved by one pass of compare-and-select logic against the link state,
// retry count, control sequence counter and ack timer, and lands in a result
// register. One event per cycle is sustained while the result side is ready,
// the throughput being set by that single state update. Ticks only run the ack
// timer down; its expiry is handled as a timeout. Configuration writes take
// effect at once and belong in idle periods.
module rts_cts_stop_and_wait_link
    import rcsw_pkg::*;
#(
    parameter int unsigned SEQ_BITS   = 8,
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    // event channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    // Low bits of a sequence number that survive the counter width
    localparam logic [7:0] SEQ_OUT_MASK =
        (SEQ_BITS >= 8) ? 8'hFF : 8'((1 << SEQ_BITS) - 1);

    typedef enum logic [3:0] {
        MODE_STANDBY   = 4'b0001,
        MODE_WAIT_CTS  = 4'b0010,
        MODE_WAIT_ACK  = 4'b0100,
        MODE_WAIT_DATA = 4'b1000
    } t_mode;

    // Configuration registers
    logic [RETRY_W-1:0]    r_max_retries;
    logic [CFG_W-1:0]      r_ack_timeout;

    // Link state
    t_mode                 r_mode, n_mode;
    logic [RETRY_W-1:0]    r_retry, n_retry;
    logic [SEQ_BITS-1:0]   r_cseq, n_cseq;
    logic [TIMER_BITS-1:0] r_tcount, n_tcount;
    logic                  r_trun, n_trun;

    // Pipeline registers
    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out, n_out;

    // Step decode
    logic                  advance;
    logic                  ev_timeout, ev_bad, ev_pkt;
    logic [7:0]            hseq, hfrag;
    logic [7:0]            pseq_m;
    logic [7:0]            cseq_out;
    logic [RETRY_W-1:0]    retry_bump;
    logic                  limit_hit;
    logic [TIMER_BITS-1:0] timer_load;

    // Handshake: move the held event into the result register when it is free
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Operand preparation
    assign hseq       = r_in.tx_has_data ? r_in.head_seq  : 8'd0;
    assign hfrag      = r_in.tx_has_data ? r_in.head_frag : 8'd0;
    assign pseq_m     = r_in.pkt_seq & SEQ_OUT_MASK;
    assign cseq_out   = 8'(r_cseq);
    assign retry_bump = (r_retry < RETRY_SAT) ? r_retry + 1'b1 : r_retry;
    assign limit_hit  = (retry_bump >= r_max_retries);
    assign timer_load = TIMER_BITS'(r_ack_timeout);

    // Resolve one event against the link state
    always_comb begin
        n_mode     = r_mode;
        n_retry    = r_retry;
        n_cseq     = r_cseq;
        n_tcount   = r_tcount;
        n_trun     = r_trun;
        n_out      = '0;
        ev_timeout = 1'b0;
        ev_bad     = 1'b0;
        ev_pkt     = 1'b0;

        // command decode: run the timer down, or kick off an RTS
        case (r_in.command)
            CMD_TICK: begin
                if (r_trun) begin
                    if (r_tcount <= TIMER_BITS'(1)) begin
                        n_tcount   = '0;
                        n_trun     = 1'b0;
                        ev_timeout = 1'b1;
                    end else begin
                        n_tcount = r_tcount - 1'b1;
                    end
                end
            end
            CMD_PKT: ev_pkt = 1'b1;
            CMD_BAD: ev_bad = 1'b1;
            default: begin
                if (r_mode == MODE_STANDBY && r_in.tx_has_data) begin
                    n_out.send_kind = SEND_CTRL;
                    n_out.send_type = PKT_RTS;
                    n_out.send_seq  = cseq_out;
                    n_cseq          = r_cseq + 1'b1;
                    if (r_in.radio_ok) begin
                        n_mode   = MODE_WAIT_CTS;
                        n_retry  = '0;
                        n_tcount = timer_load;
                        n_trun   = 1'b1;
                    end
                end
            end
        endcase

        // event handling per link state
        if (ev_timeout || ev_bad || ev_pkt) begin
            case (r_mode)
                MODE_STANDBY: begin
                    if (ev_pkt && r_in.pkt_type == PKT_RTS) begin
                        n_out.send_kind = SEND_CTRL;
                        n_out.send_type = PKT_CTS;
                        n_out.send_seq  = pseq_m;
                        if (r_in.radio_ok) begin
                            n_out.reassembly_clear = 1'b1;
                            n_retry  = '0;
                            n_mode   = MODE_WAIT_DATA;
                            n_tcount = timer_load;
                            n_trun   = 1'b1;
                        end
                    end
                end
                MODE_WAIT_CTS: begin
                    if (ev_timeout || ev_bad) begin
                        n_retry = retry_bump;
                        if (limit_hit) begin
                            n_out.queue_flush      = 1'b1;
                            n_out.app_event        = APP_TIMEOUT;
                            n_out.reassembly_clear = 1'b1;
                            n_mode   = MODE_STANDBY;
                            n_retry  = '0;
                            n_tcount = '0;
                            n_trun   = 1'b0;
                        end else begin
                            n_out.send_kind = SEND_CTRL;
                            n_out.send_type = PKT_RTS;
                            n_out.send_seq  = cseq_out;
                            n_cseq          = r_cseq + 1'b1;
                            n_tcount        = timer_load;
                            n_trun          = 1'b1;
                        end
                    end else if (r_in.pkt_type == PKT_CTS) begin
                        n_retry  = '0;
                        n_tcount = '0;
                        n_trun   = 1'b0;
                        if (r_in.tx_has_data) begin
                            n_out.send_kind = SEND_DATA;
                        end
                        if (r_in.tx_has_data && r_in.radio_ok) begin
                            n_mode   = MODE_WAIT_ACK;
                            n_tcount = timer_load;
                            n_trun   = 1'b1;
                        end else begin
                            n_out.reassembly_clear = 1'b1;
                            n_mode = MODE_STANDBY;
                        end
                    end else if (r_in.pkt_type == PKT_NACK || r_in.pkt_type == PKT_HALT) begin
                        n_out.queue_flush      = 1'b1;
                        n_out.app_event        = APP_TIMEOUT;
                        n_out.reassembly_clear = 1'b1;
                        n_mode   = MODE_STANDBY;
                        n_retry  = '0;
                        n_tcount = '0;
                        n_trun   = 1'b0;
                    end
                end
                MODE_WAIT_ACK: begin
                    if (ev_timeout || ev_bad || r_in.pkt_type == PKT_NACK) begin
                        n_retry = retry_bump;
                        if (limit_hit) begin
                            n_out.send_kind        = SEND_CTRL;
                            n_out.send_type        = PKT_HALT;
                            n_out.send_seq         = cseq_out;
                            n_cseq                 = r_cseq + 1'b1;
                            n_out.queue_flush      = 1'b1;
                            n_out.app_event        = APP_TIMEOUT;
                            n_out.reassembly_clear = 1'b1;
                            n_mode   = MODE_STANDBY;
                            n_retry  = '0;
                            n_tcount = '0;
                            n_trun   = 1'b0;
                        end else begin
                            if (r_in.tx_has_data) begin
                                n_out.send_kind = SEND_DATA;
                            end
                            n_tcount = timer_load;
                            n_trun   = 1'b1;
                        end
                    end else if (r_in.pkt_type == PKT_HALT) begin
                        n_out.queue_flush      = 1'b1;
                        n_out.app_event        = APP_TIMEOUT;
                        n_out.reassembly_clear = 1'b1;
                        n_mode   = MODE_STANDBY;
                        n_retry  = '0;
                        n_tcount = '0;
                        n_trun   = 1'b0;
                    end else if (r_in.pkt_type == PKT_ACK && r_in.pkt_seq == hseq
                                 && r_in.pkt_frag == hfrag) begin
                        n_retry             = '0;
                        n_tcount            = '0;
                        n_trun              = 1'b0;
                        n_out.queue_advance = r_in.tx_has_data;
                        if (r_in.tx_has_data && !r_in.head_is_last) begin
                            n_out.send_kind = SEND_DATA;
                        end
                        if (r_in.tx_has_data && !r_in.head_is_last && r_in.radio_ok) begin
                            n_tcount = timer_load;
                            n_trun   = 1'b1;
                        end else begin
                            n_out.reassembly_clear = 1'b1;
                            n_mode = MODE_STANDBY;
                        end
                    end
                end
                default: begin
                    // waiting for DATA
                    if (ev_timeout) begin
                        n_retry         = retry_bump;
                        n_out.send_kind = SEND_CTRL;
                        n_out.send_seq  = cseq_out;
                        n_cseq          = r_cseq + 1'b1;
                        if (limit_hit) begin
                            n_out.send_type        = PKT_HALT;
                            n_out.reassembly_clear = 1'b1;
                            n_mode   = MODE_STANDBY;
                            n_retry  = '0;
                            n_tcount = '0;
                            n_trun   = 1'b0;
                        end else begin
                            n_out.send_type = PKT_NACK;
                            n_tcount        = timer_load;
                            n_trun          = 1'b1;
                        end
                    end else if (ev_bad) begin
                        n_out.send_kind = SEND_CTRL;
                        n_out.send_type = PKT_NACK;
                        n_out.send_seq  = cseq_out;
                        n_cseq          = r_cseq + 1'b1;
                        n_tcount        = timer_load;
                        n_trun          = 1'b1;
                    end else if (r_in.pkt_type == PKT_HALT) begin
                        n_out.reassembly_clear = 1'b1;
                        n_mode   = MODE_STANDBY;
                        n_retry  = '0;
                        n_tcount = '0;
                        n_trun   = 1'b0;
                    end else if (r_in.pkt_type == PKT_DATA) begin
                        n_out.send_kind = SEND_CTRL;
                        if (!r_in.frag_accepted) begin
                            n_out.send_type = PKT_NACK;
                            n_out.send_seq  = cseq_out;
                            n_cseq          = r_cseq + 1'b1;
                            n_tcount        = timer_load;
                            n_trun          = 1'b1;
                        end else begin
                            n_out.send_type = PKT_ACK;
                            n_out.send_seq  = pseq_m;
                            n_out.send_frag = r_in.pkt_frag;
                            n_retry         = '0;
                            if (r_in.message_complete) begin
                                n_out.app_event        = APP_DELIVERED;
                                n_out.reassembly_clear = 1'b1;
                                n_mode   = MODE_STANDBY;
                                n_tcount = '0;
                                n_trun   = 1'b0;
                            end else begin
                                n_tcount = timer_load;
                                n_trun   = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        // report the link state after the step
        case (n_mode)
            MODE_STANDBY:   n_out.link_state = LINK_STANDBY;
            MODE_WAIT_CTS:  n_out.link_state = LINK_WAIT_CTS;
            MODE_WAIT_ACK:  n_out.link_state = LINK_WAIT_ACK;
            MODE_WAIT_DATA: n_out.link_state = LINK_WAIT_DATA;
            default:        n_out.link_state = LINK_STANDBY;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= MAX_RETRIES_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data[RETRY_W-1:0];
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default:         r_ack_timeout <= r_ack_timeout;
            endcase
        end
    end

    // Link state: advance once per resolved event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_STANDBY;
            r_retry  <= '0;
            r_cseq   <= '0;
            r_tcount <= '0;
            r_trun   <= 1'b0;
        end else if (advance) begin
            r_mode   <= n_mode;
            r_retry  <= n_retry;
            r_cseq   <= n_cseq;
            r_tcount <= n_tcount;
            r_trun   <= n_trun;
        end
    end

    // Input register: capture a transfer, drop it once resolved
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Result register: hold until the result transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== tb/sv/tb_link_board_pkg.sv =====
`timescale 1ns / 1ps
// Result board for the RTS/CTS stop-and-wait link testbench: predicts each link result.
// Checks the block's results in order against that prediction.
// Depends on rcsw_pkg for the payload structs and the codes.
package tb_link_board_pkg;
    import rcsw_pkg::*;

    class link_result_board;
        // Register copies
        logic [RETRY_W-1:0] retry_limit;
        logic [CFG_W-1:0]   ack_ticks;
        // Link state copies
        logic [1:0]         mode;
        logic [RETRY_W-1:0] retries_used;
        logic [7:0]         ctrl_seq;
        logic [15:0]        ack_timer;
        bit                 timer_on;
        // Results predicted but not yet seen
        t_out_item          expected_results[$];
        int unsigned        mismatches;

        function new();
            retry_limit  = MAX_RETRIES_RESET;
            ack_ticks    = ACK_TIMEOUT_RESET;
            mode         = LINK_STANDBY;
            retries_used = '0;
            ctrl_seq     = '0;
            ack_timer    = '0;
            timer_on     = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_config(logic [RETRY_W-1:0] retries, logic [CFG_W-1:0] ticks);
            retry_limit = retries;
            ack_ticks   = ticks;
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction

        function void start_timer();
            ack_timer = ack_ticks;
            timer_on  = 1'b1;
        endfunction

        function void stop_timer();
            ack_timer = '0;
            timer_on  = 1'b0;
        endfunction

        function void go_standby(inout t_out_item r);
            stop_timer();
            retries_used       = '0;
            mode               = LINK_STANDBY;
            r.reassembly_clear = 1'b1;
        endfunction

        function void send_ctrl(inout t_out_item r, input logic [2:0] kind_of_pkt,
                                input logic [7:0] seq, input logic [7:0] frag);
            r.send_kind = SEND_CTRL;
            r.send_type = kind_of_pkt;
            r.send_seq  = seq;
            r.send_frag = frag;
        endfunction

        // Send a control packet that takes the next control sequence number
        function void send_numbered(inout t_out_item r, input logic [2:0] kind_of_pkt);
            send_ctrl(r, kind_of_pkt, ctrl_seq, 8'd0);
            ctrl_seq = ctrl_seq + 8'd1;
        endfunction

        // Count one failed attempt; true once the limit is reached
        function bit count_retry();
            if (retries_used < RETRY_SAT)
                retries_used = retries_used + 1'b1;
            return retries_used >= retry_limit;
        endfunction

        function void give_up(inout t_out_item r);
            r.queue_flush = 1'b1;
            r.app_event   = APP_TIMEOUT;
            go_standby(r);
        endfunction

        // Work out the result of one accepted event and queue it
        function void note_event(t_in_item ev);
            t_out_item  r;
            bit         expired;
            bit         bad;
            bit         pkt;
            logic [7:0] hseq;
            logic [7:0] hfrag;
            r       = '0;
            expired = 1'b0;
            bad     = 1'b0;
            pkt     = 1'b0;
            hseq    = ev.tx_has_data ? ev.head_seq : 8'd0;
            hfrag   = ev.tx_has_data ? ev.head_frag : 8'd0;

            case (ev.command)
                CMD_TICK: begin
                    if (timer_on) begin
                        if (ack_timer <= 16'd1) begin
                            stop_timer();
                            expired = 1'b1;
                        end else begin
                            ack_timer = ack_timer - 16'd1;
                        end
                    end
                end
                CMD_PKT: pkt = 1'b1;
                CMD_BAD: bad = 1'b1;
                default: begin
                    if (mode == LINK_STANDBY && ev.tx_has_data) begin
                        send_numbered(r, PKT_RTS);
                        if (ev.radio_ok) begin
                            mode         = LINK_WAIT_CTS;
                            retries_used = '0;
                            start_timer();
                        end
                    end
                end
            endcase

            if (expired || bad || pkt) begin
                case (mode)
                    LINK_STANDBY: begin
                        if (pkt && ev.pkt_type == PKT_RTS) begin
                            send_ctrl(r, PKT_CTS, ev.pkt_seq, 8'd0);
                            if (ev.radio_ok) begin
                                r.reassembly_clear = 1'b1;
                                retries_used       = '0;
                                mode               = LINK_WAIT_DATA;
                                start_timer();
                            end
                        end
                    end
                    LINK_WAIT_CTS: begin
                        if (expired || bad) begin
                            if (count_retry()) begin
                                give_up(r);
                            end else begin
                                send_numbered(r, PKT_RTS);
                                start_timer();
                            end
                        end else if (ev.pkt_type == PKT_CTS) begin
                            stop_timer();
                            retries_used = '0;
                            if (!ev.tx_has_data) begin
                                go_standby(r);
                            end else begin
                                r.send_kind = SEND_DATA;
                                if (ev.radio_ok) begin
                                    mode = LINK_WAIT_ACK;
                                    start_timer();
                                end else begin
                                    go_standby(r);
                                end
                            end
                        end else if (ev.pkt_type == PKT_NACK || ev.pkt_type == PKT_HALT) begin
                            give_up(r);
                        end
                    end
                    LINK_WAIT_ACK: begin
                        if (expired || bad || ev.pkt_type == PKT_NACK) begin
                            if (count_retry()) begin
                                send_numbered(r, PKT_HALT);
                                give_up(r);
                            end else begin
                                if (ev.tx_has_data)
                                    r.send_kind = SEND_DATA;
                                start_timer();
                            end
                        end else if (ev.pkt_type == PKT_HALT) begin
                            give_up(r);
                        end else if (ev.pkt_type == PKT_ACK && ev.pkt_seq == hseq
                                     && ev.pkt_frag == hfrag) begin
                            stop_timer();
                            retries_used    = '0;
                            r.queue_advance = ev.tx_has_data;
                            if (!ev.tx_has_data || ev.head_is_last) begin
                                go_standby(r);
                            end else begin
                                r.send_kind = SEND_DATA;
                                if (ev.radio_ok)
                                    start_timer();
                                else
                                    go_standby(r);
                            end
                        end
                    end
                    default: begin
                        if (expired) begin
                            if (count_retry()) begin
                                send_numbered(r, PKT_HALT);
                                go_standby(r);
                            end else begin
                                send_numbered(r, PKT_NACK);
                                start_timer();
                            end
                        end else if (bad) begin
                            send_numbered(r, PKT_NACK);
                            start_timer();
                        end else if (ev.pkt_type == PKT_HALT) begin
                            go_standby(r);
                        end else if (ev.pkt_type == PKT_DATA) begin
                            if (!ev.frag_accepted) begin
                                send_numbered(r, PKT_NACK);
                                start_timer();
                            end else begin
                                send_ctrl(r, PKT_ACK, ev.pkt_seq, ev.pkt_frag);
                                retries_used = '0;
                                if (ev.message_complete) begin
                                    r.app_event = APP_DELIVERED;
                                    go_standby(r);
                                end else begin
                                    start_timer();
                                end
                            end
                        end
                    end
                endcase
            end

            r.link_state = mode;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
                compare_field("send_type", 32'(want.send_type), 32'(got.send_type));
                compare_field("send_seq", 32'(want.send_seq), 32'(got.send_seq));
                compare_field("send_frag", 32'(want.send_frag), 32'(got.send_frag));
                compare_field("app_event", 32'(want.app_event), 32'(got.app_event));
                compare_field("queue_advance", 32'(want.queue_advance),
                              32'(got.queue_advance));
                compare_field("queue_flush", 32'(want.queue_flush), 32'(got.queue_flush));
                compare_field("reassembly_clear", 32'(want.reassembly_clear),
                              32'(got.reassembly_clear));
                compare_field("link_state", 32'(want.link_state), 32'(got.link_state));
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_rts_cts_stop_and_wait_link.sv =====
`timescale 1ns / 1ps
// Top-level testbench for rts_cts_stop_and_wait_link: directed and mode-aware random
// link events with bursty input and a stalling result side.
// Depends on rcsw_pkg, tb_link_board_pkg and the block's RTL.
module tb_rts_cts_stop_and_wait_link;
    import rcsw_pkg::*;
    import tb_link_board_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_data;

    link_result_board board;
    int unsigned      ready_cycle = 0;
    int unsigned      ready_style = 0;

    rts_cts_stop_and_wait_link DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Check each result transfer, then pick the next stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            board.check_result(o_out_data);
        ready_cycle++;
        if (ready_cycle % 101 == 0)
            ready_style = $urandom_range(0, 4);
        case (ready_style)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= (ready_cycle % 3 == 0);
            3: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (ready_cycle % 16 >= 10);
        endcase
    end

    function automatic t_in_item make_item(logic [1:0] cmd, logic [2:0] ptype,
                                           logic [7:0] pseq, logic [7:0] pfrag,
                                           int unsigned ok, int unsigned has,
                                           logic [7:0] hseq, logic [7:0] hfrag,
                                           int unsigned last, int unsigned acc,
                                           int unsigned cpl);
        t_in_item ev;
        ev.command          = cmd;
        ev.pkt_type         = ptype;
        ev.pkt_seq          = pseq;
        ev.pkt_frag         = pfrag;
        ev.radio_ok         = 1'(ok);
        ev.tx_has_data      = 1'(has);
        ev.head_seq         = hseq;
        ev.head_frag        = hfrag;
        ev.head_is_last     = 1'(last);
        ev.frag_accepted    = 1'(acc);
        ev.message_complete = 1'(cpl);
        return ev;
    endfunction

    // Pick an event that suits the current link state; some are pure noise
    function automatic t_in_item next_event(logic [1:0] link_mode);
        t_in_item    ev;
        int unsigned pick;
        ev.command          = 2'($urandom_range(0, 3));
        ev.pkt_type         = 3'($urandom_range(0, 7));
        ev.pkt_seq          = 8'($urandom_range(0, 255));
        ev.pkt_frag         = 8'($urandom_range(0, 255));
        ev.radio_ok         = 1'($urandom_range(0, 1));
        ev.tx_has_data      = 1'($urandom_range(0, 1));
        ev.head_seq         = 8'($urandom_range(0, 255));
        ev.head_frag        = 8'($urandom_range(0, 255));
        ev.head_is_last     = 1'($urandom_range(0, 1));
        ev.frag_accepted    = 1'($urandom_range(0, 1));
        ev.message_complete = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick >= 20) begin
            ev.radio_ok         = ($urandom_range(0, 9) != 0);
            ev.tx_has_data      = ($urandom_range(0, 7) != 0);
            ev.head_is_last     = ($urandom_range(0, 3) == 0);
            ev.frag_accepted    = ($urandom_range(0, 6) != 0);
            ev.message_complete = ($urandom_range(0, 4) == 0);
            ev.command          = CMD_PKT;
            case (link_mode)
                LINK_STANDBY: begin
                    if (pick < 60)
                        ev.command = CMD_KICK;
                    else
                        ev.pkt_type = PKT_RTS;
                end
                LINK_WAIT_CTS: begin
                    if (pick < 65)
                        ev.pkt_type = PKT_CTS;
                    else if (pick < 80)
                        ev.command = CMD_TICK;
                    else if (pick < 90)
                        ev.command = CMD_BAD;
                    else
                        ev.pkt_type = $urandom_range(0, 1) ? PKT_NACK : PKT_HALT;
                end
                LINK_WAIT_ACK: begin
                    if (pick < 60) begin
                        ev.pkt_type = PKT_ACK;
                        ev.pkt_seq  = ev.head_seq;
                        ev.pkt_frag = ev.head_frag;
                    end else if (pick < 72) begin
                        ev.pkt_type = PKT_NACK;
                    end else if (pick < 88) begin
                        ev.command = CMD_TICK;
                    end else if (pick < 94) begin
                        ev.command = CMD_BAD;
                    end else begin
                        ev.pkt_type = PKT_HALT;
                    end
                end
                default: begin
                    if (pick < 65)
                        ev.pkt_type = PKT_DATA;
                    else if (pick < 82)
                        ev.command = CMD_TICK;
                    else if (pick < 92)
                        ev.command = CMD_BAD;
                    else
                        ev.pkt_type = PKT_HALT;
                end
            endcase
        end
        return ev;
    endfunction

    // Hold the event on the channel until the transfer happens
    task automatic send_event(input t_in_item ev);
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.note_event(ev);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [RETRY_W-1:0] retries,
                                input logic [CFG_W-1:0] ticks);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_RETRIES;
        i_cfg_data <= CFG_W'(retries);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACK_TIMEOUT;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_config(retries, ticks);
    endtask

    // Random events in bursts, with a full pause halfway through
    task automatic random_events(input int unsigned count);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 24);
        for (int unsigned n = 0; n < count; n++) begin
            send_event(next_event(board.mode));
            if (n == count / 2 || $urandom_range(0, 199) == 0) begin
                drain();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end
    endtask

    task automatic run_phase(input logic [RETRY_W-1:0] retries,
                             input logic [CFG_W-1:0] ticks);
        drain();
        write_config(retries, ticks);
        random_events(200);
    endtask

    initial begin
        board = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MAX_RETRIES;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle cases, a send given up on HALT and a full receive
        send_event(make_item(CMD_TICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_BAD, PKT_DATA, 8'h00, 8'h00, 1, 1, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 0, 8'hFF, 8'hFF, 1, 1, 1));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 0, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_PKT, 3'd7, 8'hFF, 8'hFF, 1, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_CTS, 8'h00, 8'h00, 1, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_ACK, 8'h00, 8'h00, 1, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_ACK, 8'hFF, 8'hFF, 1, 1, 8'hFF, 8'hFF, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_NACK, 8'h00, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_HALT, 8'h00, 8'h00, 1, 1, 8'h01, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_RTS, 8'hFF, 8'h7F, 1, 0, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_DATA, 8'h01, 8'h02, 1, 0, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_BAD, PKT_DATA, 8'h00, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_DATA, 8'hAA, 8'h55, 1, 0, 8'h00, 8'h00, 0, 1, 0));
        send_event(make_item(CMD_PKT, PKT_DATA, 8'h55, 8'hAA, 1, 0, 8'h00, 8'h00, 0, 1, 1));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h01, 8'h02, 1, 0, 0));
        send_event(make_item(CMD_PKT, PKT_CTS, 8'h00, 8'h00, 1, 0, 8'h00, 8'h00, 0, 0, 0));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h01, 8'h02, 1, 0, 0));
        send_event(make_item(CMD_PKT, PKT_NACK, 8'h00, 8'h00, 1, 1, 8'h01, 8'h02, 1, 0, 0));

        // Zero retry limit and zero timer load: first failure gives up
        drain();
        write_config(4'd0, 16'd0);
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_TICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_RTS, 8'h33, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_TICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_KICK, PKT_RTS, 8'h00, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_CTS, 8'h00, 8'h00, 1, 1, 8'h10, 8'h20, 0, 0, 0));
        send_event(make_item(CMD_PKT, PKT_ACK, 8'h00, 8'h00, 1, 0, 8'h10, 8'h20, 0, 0, 0));

        // Random phases across the register range
        run_phase(4'd1, 16'd1);
        run_phase(4'd15, 16'd2);
        run_phase(4'd2, 16'd0);
        run_phase(4'd4, 16'd7);
        run_phase(4'd15, 16'hFFFF);
        run_phase(4'd3, 16'd3);

        drain();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
src/rcsw_pkg.sv
src/rts_cts_stop_and_wait_link.sv
tb/sv/tb_link_board_pkg.sv
tb/sv/tb_rts_cts_stop_and_wait_link.sv
